// ----- design/tcw_pkg.sv -----
// Shared types and constants for the text console writer.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

  // Widths of the words that cross the ports.
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned ROWF_W  = 5;
  localparam int unsigned COLF_W  = 7;
  localparam int unsigned LOC_W   = 16;

  // Item modes.
  localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READ  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  // Control characters.
  localparam logic [CHAR_W-1:0] KEY_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0] KEY_CR        = 8'h0D;
  localparam logic [CHAR_W-1:0] KEY_LF        = 8'h0A;

  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h00;
  localparam logic [CHAR_W-1:0] RESET_ATTR = 8'h0F;

  // Number of command words the queue between front and back can hold.
  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    OP_PRINT,
    OP_BS,
    OP_CR,
    OP_LF,
    OP_READ,
    OP_CLEAR,
    OP_NOP
  } op_e;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_RWAIT,
    ST_SCROLL,
    ST_BLANK,
    ST_DONE
  } state_e;

  typedef struct packed {
    op_e               op;
    logic [CHAR_W-1:0] ch;
    logic [ROWF_W-1:0] row;
    logic [COLF_W-1:0] col;
    logic              in_range;
  } cmd_t;

endpackage

`default_nettype wire

// ----- design/tcw_in_if.sv -----
// Input channel of the text console writer.
`timescale 1ns / 1ps
`default_nettype none

interface tcw_in_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [CHAR_W-1:0] char_code;
  logic [ROWF_W-1:0] cell_row;
  logic [COLF_W-1:0] cell_col;

  modport source (output valid, output mode, output char_code, output cell_row,
                  output cell_col, input ready);
  modport sink (input valid, input mode, input char_code, input cell_row,
                input cell_col, output ready);
endinterface

`default_nettype wire

// ----- design/tcw_out_if.sv -----
// Result channel of the text console writer.
`timescale 1ns / 1ps
`default_nettype none

interface tcw_out_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ROWF_W-1:0] cursor_row;
  logic [COLF_W-1:0] cursor_col;
  logic [LOC_W-1:0]  cursor_location;
  logic [CHAR_W-1:0] cell_char;
  logic [CHAR_W-1:0] cell_attr;

  modport source (output valid, output cursor_row, output cursor_col,
                  output cursor_location, output cell_char, output cell_attr,
                  input ready);
  modport sink (input valid, input cursor_row, input cursor_col,
                input cursor_location, input cell_char, input cell_attr,
                output ready);
endinterface

`default_nettype wire

// ----- design/tcw_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none

module tcw_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1920,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- design/tcw_front.sv -----
// Front end: takes input words and classifies them into commands.
`timescale 1ns / 1ps
`default_nettype none

module tcw_front import tcw_pkg::*; #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  tcw_in_if.sink     in_i,
  input  wire logic  full_i,
  output logic       push_o,
  output cmd_t       cmd_o
);

  localparam int unsigned USABLE_ROWS = ROWS - 1;

  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && !full_i;

  always_comb begin
    cmd_o.ch       = in_i.char_code;
    cmd_o.row      = in_i.cell_row;
    cmd_o.col      = in_i.cell_col;
    cmd_o.in_range = (in_i.cell_row < USABLE_ROWS) && (in_i.cell_col < COLUMNS);
    unique case (in_i.mode)
      MODE_PUT: begin
        unique case (in_i.char_code)
          KEY_BACKSPACE: cmd_o.op = OP_BS;
          KEY_CR:        cmd_o.op = OP_CR;
          KEY_LF:        cmd_o.op = OP_LF;
          default:       cmd_o.op = OP_PRINT;
        endcase
      end
      MODE_READ:  cmd_o.op = OP_READ;
      MODE_CLEAR: cmd_o.op = OP_CLEAR;
      default:    cmd_o.op = OP_NOP;
    endcase
  end

endmodule

`default_nettype wire

// ----- design/tcw_cmd_queue.sv -----
// Two-entry command queue between the front end and the execution engine.
`timescale 1ns / 1ps
`default_nettype none

module tcw_cmd_queue import tcw_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t cmd_i,
  input  wire logic pop_i,
  output cmd_t      cmd_o,
  output logic      full_o,
  output logic      empty_o
);

  localparam int unsigned PtrW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  cmd_t            mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;

  assign full_o  = (count_q == CntW'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign cmd_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

`default_nettype wire

// ----- design/tcw_back.sv -----
// Execution engine: cursor, cell store, scroll and clear sweeps, result register.
`timescale 1ns / 1ps
`default_nettype none

module tcw_back import tcw_pkg::*; #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CHAR_W-1:0] cfg_wdata_i,
  input  wire logic              q_empty_i,
  input  wire cmd_t              q_cmd_i,
  output logic                   q_pop_o,
  tcw_out_if.source              out_o
);

  localparam int unsigned USABLE_ROWS  = ROWS - 1;
  localparam int unsigned CELL_COUNT   = USABLE_ROWS * COLUMNS;
  localparam int unsigned SCROLL_CELLS = (USABLE_ROWS - 1) * COLUMNS;
  localparam int unsigned AW = $clog2(CELL_COUNT);
  localparam int unsigned RW = (USABLE_ROWS > 1) ? $clog2(USABLE_ROWS) : 1;
  localparam int unsigned CW = $clog2(COLUMNS);

  state_e            state_q, state_d;
  logic [AW-1:0]     ptr_q, ptr_d;
  logic [RW-1:0]     row_q, row_d;
  logic [CW-1:0]     col_q, col_d;
  cmd_t              cmd_q, cmd_d;
  logic [CHAR_W-1:0] rd_char_q, rd_char_d;
  logic [CHAR_W-1:0] rd_attr_q, rd_attr_d;
  logic [CHAR_W-1:0] text_attr_q;

  logic              out_valid_q, out_valid_d;
  logic              out_load;
  logic [ROWF_W-1:0] o_row_q;
  logic [COLF_W-1:0] o_col_q;
  logic [LOC_W-1:0]  o_loc_q;
  logic [CHAR_W-1:0] o_char_q, o_attr_q;

  logic [AW-1:0]     row_base, idx_cur, rd_addr;
  logic [CW:0]       col_inc;
  logic              row_last;
  logic              need_row;
  logic [LOC_W-1:0]  loc;

  logic              char_we, attr_we;
  logic [AW-1:0]     waddr, raddr;
  logic [CHAR_W-1:0] wchar, wattr, rchar, rattr;

  assign row_base = AW'(row_q * COLUMNS);
  assign idx_cur  = row_base + AW'(col_q);
  assign rd_addr  = AW'(cmd_q.row * COLUMNS) + AW'(cmd_q.col);
  assign col_inc  = {1'b0, col_q} + 1'b1;
  assign row_last = (({1'b0, row_q} + 1'b1) >= (RW + 1)'(USABLE_ROWS));
  // Hardware cursor location keeps the off-by-one and wraps at 16 bits.
  assign loc      = LOC_W'(row_base) + LOC_W'(col_q) - 16'd1;

  tcw_ram #(.WIDTH(CHAR_W), .DEPTH(CELL_COUNT)) u_char_ram (
    .clk_i   (clk_i),
    .we_i    (char_we),
    .waddr_i (waddr),
    .wdata_i (wchar),
    .raddr_i (raddr),
    .rdata_o (rchar)
  );

  tcw_ram #(.WIDTH(CHAR_W), .DEPTH(CELL_COUNT)) u_attr_ram (
    .clk_i   (clk_i),
    .we_i    (attr_we),
    .waddr_i (waddr),
    .wdata_i (wattr),
    .raddr_i (raddr),
    .rdata_o (rattr)
  );

  always_comb begin
    state_d   = state_q;
    ptr_d     = ptr_q;
    row_d     = row_q;
    col_d     = col_q;
    cmd_d     = cmd_q;
    rd_char_d = rd_char_q;
    rd_attr_d = rd_attr_q;
    q_pop_o   = 1'b0;
    out_load  = 1'b0;
    need_row  = 1'b0;
    char_we   = 1'b0;
    attr_we   = 1'b0;
    waddr     = idx_cur;
    wchar     = BLANK_CHAR;
    wattr     = text_attr_q;
    raddr     = rd_addr;

    unique case (state_q)
      ST_INIT: begin
        char_we = 1'b1;
        attr_we = 1'b1;
        waddr   = ptr_q;
        wattr   = RESET_ATTR;
        ptr_d   = ptr_q + 1'b1;
        if (ptr_q == AW'(CELL_COUNT - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          cmd_d   = q_cmd_i;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        rd_char_d = '0;
        rd_attr_d = '0;
        state_d   = ST_DONE;
        unique case (cmd_q.op)
          OP_PRINT: begin
            char_we = 1'b1;
            attr_we = 1'b1;
            wchar   = cmd_q.ch;
            if (col_inc == (CW + 1)'(COLUMNS)) begin
              col_d    = '0;
              need_row = 1'b1;
            end else begin
              col_d = col_inc[CW-1:0];
            end
          end
          OP_BS: begin
            // Only the character is cleared; the attribute stays.
            if (col_q != '0) begin
              col_d   = col_q - 1'b1;
              char_we = 1'b1;
              waddr   = idx_cur - 1'b1;
            end
          end
          OP_CR: begin
            col_d = '0;
          end
          OP_LF: begin
            col_d    = '0;
            need_row = 1'b1;
          end
          OP_READ: begin
            if (cmd_q.in_range) begin
              state_d = ST_RWAIT;
            end
          end
          OP_CLEAR: begin
            row_d   = '0;
            col_d   = '0;
            ptr_d   = '0;
            state_d = ST_BLANK;
          end
          default: begin
          end
        endcase
        if (need_row) begin
          if (row_last) begin
            ptr_d   = '0;
            state_d = ST_SCROLL;
          end else begin
            row_d = row_q + 1'b1;
          end
        end
      end
      ST_RWAIT: begin
        rd_char_d = rchar;
        rd_attr_d = rattr;
        state_d   = ST_DONE;
      end
      ST_SCROLL: begin
        // Read one row ahead; the next cycle writes the read data one row up.
        raddr = ptr_q + AW'(COLUMNS);
        if (ptr_q != '0) begin
          char_we = 1'b1;
          attr_we = 1'b1;
          waddr   = ptr_q - 1'b1;
          wchar   = rchar;
          wattr   = rattr;
        end
        if (ptr_q == AW'(SCROLL_CELLS)) begin
          state_d = ST_BLANK;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      ST_BLANK: begin
        char_we = 1'b1;
        attr_we = 1'b1;
        waddr   = ptr_q;
        if (ptr_q == AW'(CELL_COUNT - 1)) begin
          state_d = ST_DONE;
        end else begin
          ptr_d = ptr_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || out_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      ptr_q       <= '0;
      row_q       <= '0;
      col_q       <= '0;
      text_attr_q <= RESET_ATTR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      row_q       <= row_d;
      col_q       <= col_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        text_attr_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    rd_char_q <= rd_char_d;
    rd_attr_q <= rd_attr_d;
    if (out_load) begin
      o_row_q  <= ROWF_W'(row_q);
      o_col_q  <= COLF_W'(col_q);
      o_loc_q  <= loc;
      o_char_q <= rd_char_q;
      o_attr_q <= rd_attr_q;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.cursor_row      = o_row_q;
  assign out_o.cursor_col      = o_col_q;
  assign out_o.cursor_location = o_loc_q;
  assign out_o.cell_char       = o_char_q;
  assign out_o.cell_attr       = o_attr_q;

  a_cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_q < USABLE_ROWS) && (col_q < COLUMNS))
    else $error("cursor left the usable screen area");

  a_write_in_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (char_we || attr_we) |-> (waddr < CELL_COUNT))
    else $error("cell store write beyond its depth");

  a_result_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
    else $error("result word raised outside the completion step");

  a_scroll_covers_rows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCROLL && state_d == ST_BLANK) |=> (ptr_q == AW'(SCROLL_CELLS)))
    else $error("scroll ended before all rows were moved");

endmodule

`default_nettype wire

// ----- design/text_console_writer.sv -----
// Top level of the text console writer: front end, command queue and execution engine.
//
// Usage: command words enter on in_i (valid/ready). Mode 0 puts a character
// (backspace, CR and LF are interpreted), mode 1 reads one cell, mode 2 clears
// the screen and homes the cursor. Every accepted word yields exactly one
// result word on out_o (valid/ready) carrying the cursor, the hardware cursor
// location and, for reads, the cell's character and attribute.
// The attribute used for characters and blanks is written through cfg_we_i and
// cfg_wdata_i; the user must do so while the block is idle, which is not enforced.
// Flow: the engine pops an accepted word from the queue in IDLE, runs it in EXEC
// and loads the result register in DONE once that register is free; an in-range
// read also passes RWAIT, and no new word is taken before DONE. A word that scrolls
// moves the lower rows up and blanks the last row; a clear blanks every cell. Both
// sweeps use the single write port of the cell store, which moves one cell per cycle.
// Reset: the cursor goes home, the attribute becomes 0x0F, and a clearing pass
// over all (ROWS-1)*COLUMNS cells (1920 by default) fills the store with blanks;
// up to two words are queued meanwhile, then in_i.ready drops.
// Stalls: a two-word queue and the result register let input keep flowing while
// out_o is held; once both are full, in_i.ready stays low until out_o drains.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer import tcw_pkg::*; #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [CHAR_W-1:0] cfg_wdata_i,
  tcw_in_if.sink                 in_i,
  tcw_out_if.source              out_o
);

  logic push, pop, full, empty;
  cmd_t front_cmd, queue_cmd;

  tcw_front #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_front (
    .in_i   (in_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (front_cmd)
  );

  tcw_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (front_cmd),
    .pop_i   (pop),
    .cmd_o   (queue_cmd),
    .full_o  (full),
    .empty_o (empty)
  );

  tcw_back #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .q_empty_i   (empty),
    .q_cmd_i     (queue_cmd),
    .q_pop_o     (pop),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

// ----- dv/tb_top.sv -----
// Self-checking testbench for the text console writer: table-driven and random words.
`timescale 1ns / 1ps

module tb_top import tcw_pkg::*; ;

  localparam int COLS       = 80;
  localparam int TEXT_ROWS  = 24;
  localparam int CELLS      = TEXT_ROWS * COLS;
  localparam int STALL_LIMIT = 20000;
  localparam int REPORT_MAX = 10;
  localparam int PHASE_WORDS = 260;

  // Mode 3 has no meaning; the block must ignore it.
  localparam logic [MODE_W-1:0] MODE_RESERVED = 2'd3;

  typedef struct packed {
    logic [ROWF_W-1:0] cursor_row;
    logic [COLF_W-1:0] cursor_col;
    logic [LOC_W-1:0]  cursor_location;
    logic [CHAR_W-1:0] cell_char;
    logic [CHAR_W-1:0] cell_attr;
  } console_report_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CHAR_W-1:0] ch;
    logic [ROWF_W-1:0] row;
    logic [COLF_W-1:0] col;
    logic              typed;
    console_report_t   want;
  } directed_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CHAR_W-1:0] cfg_wdata_i;

  tcw_in_if  in_ch ();
  tcw_out_if out_ch ();

  text_console_writer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_ch),
    .out_o       (out_ch)
  );

  // Shadow copy of the screen, cursor and attribute register.
  logic [CHAR_W-1:0] screen_char [CELLS];
  logic [CHAR_W-1:0] screen_attr [CELLS];
  int                cursor_row_q;
  int                cursor_col_q;
  logic [CHAR_W-1:0] text_attr_q;

  console_report_t expected_reports [$];
  directed_row_t   directed_rows [$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned error_count;
  int unsigned stall_cycles;
  int unsigned words_sent;

  initial clk_i = 1'b0;
  always #1 clk_i = ~clk_i;

  function automatic void screen_blank_row(input int r);
    for (int c = 0; c < COLS; c++) begin
      screen_char[r * COLS + c] = BLANK_CHAR;
      screen_attr[r * COLS + c] = text_attr_q;
    end
  endfunction

  function automatic void screen_scroll_up();
    for (int i = 0; i < CELLS - COLS; i++) begin
      screen_char[i] = screen_char[i + COLS];
      screen_attr[i] = screen_attr[i + COLS];
    end
    screen_blank_row(TEXT_ROWS - 1);
  endfunction

  function automatic void screen_put_char(input logic [CHAR_W-1:0] ch);
    if (ch == KEY_BACKSPACE) begin
      if (cursor_col_q > 0) begin
        cursor_col_q--;
        screen_char[cursor_row_q * COLS + cursor_col_q] = BLANK_CHAR;
      end
    end else if (ch == KEY_CR) begin
      cursor_col_q = 0;
    end else if (ch == KEY_LF) begin
      cursor_col_q = 0;
      cursor_row_q++;
    end else begin
      screen_char[cursor_row_q * COLS + cursor_col_q] = ch;
      screen_attr[cursor_row_q * COLS + cursor_col_q] = text_attr_q;
      cursor_col_q++;
    end
    if (cursor_col_q >= COLS) begin
      cursor_col_q = 0;
      cursor_row_q++;
    end
    if (cursor_row_q >= TEXT_ROWS) begin
      screen_scroll_up();
      cursor_row_q--;
    end
  endfunction

  function automatic console_report_t predict_console(input logic [MODE_W-1:0] mode,
                                                      input logic [CHAR_W-1:0] ch,
                                                      input logic [ROWF_W-1:0] row,
                                                      input logic [COLF_W-1:0] col);
    console_report_t rep;
    rep = '0;
    if (mode == MODE_PUT) begin
      screen_put_char(ch);
    end else if (mode == MODE_READ) begin
      if (row < TEXT_ROWS && col < COLS) begin
        rep.cell_char = screen_char[row * COLS + col];
        rep.cell_attr = screen_attr[row * COLS + col];
      end
    end else if (mode == MODE_CLEAR) begin
      for (int r = 0; r < TEXT_ROWS; r++) screen_blank_row(r);
      cursor_row_q = 0;
      cursor_col_q = 0;
    end
    rep.cursor_row      = ROWF_W'(cursor_row_q);
    rep.cursor_col      = COLF_W'(cursor_col_q);
    rep.cursor_location = LOC_W'(cursor_row_q * COLS + cursor_col_q - 1);
    return rep;
  endfunction

  function automatic directed_row_t row_typed(input logic [MODE_W-1:0] m,
                                              input logic [CHAR_W-1:0] ch,
                                              input logic [ROWF_W-1:0] r,
                                              input logic [COLF_W-1:0] c,
                                              input logic [ROWF_W-1:0] er,
                                              input logic [COLF_W-1:0] ec,
                                              input logic [LOC_W-1:0] el,
                                              input logic [CHAR_W-1:0] xc,
                                              input logic [CHAR_W-1:0] xa);
    directed_row_t d;
    d.mode  = m;
    d.ch    = ch;
    d.row   = r;
    d.col   = c;
    d.typed = 1'b1;
    d.want  = '{er, ec, el, xc, xa};
    return d;
  endfunction

  function automatic directed_row_t row_predicted(input logic [MODE_W-1:0] m,
                                                  input logic [CHAR_W-1:0] ch,
                                                  input logic [ROWF_W-1:0] r,
                                                  input logic [COLF_W-1:0] c);
    directed_row_t d;
    d       = '0;
    d.mode  = m;
    d.ch    = ch;
    d.row   = r;
    d.col   = c;
    return d;
  endfunction

  function automatic logic [CHAR_W-1:0] random_char();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 6) return KEY_BACKSPACE;
    if (pick < 9) return KEY_CR;
    if (pick < 11) return KEY_LF;
    return CHAR_W'($urandom_range(255));
  endfunction

  // Drives one word at the falling edge and predicts its report once it is taken.
  task automatic send_word(input logic [MODE_W-1:0] mode, input logic [CHAR_W-1:0] ch,
                           input logic [ROWF_W-1:0] row, input logic [COLF_W-1:0] col,
                           input logic typed, input console_report_t want);
    console_report_t rep;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.mode      <= mode;
    in_ch.char_code <= ch;
    in_ch.cell_row  <= row;
    in_ch.cell_col  <= col;
    do @(posedge clk_i); while (!in_ch.ready);
    rep = predict_console(mode, ch, row, col);
    expected_reports.push_back(typed ? want : rep);
    if (mode != MODE_RESERVED) words_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_put(input logic [CHAR_W-1:0] ch);
    send_word(MODE_PUT, ch, ROWF_W'($urandom), COLF_W'($urandom), 1'b0, '0);
  endtask

  task automatic send_plain(input logic [MODE_W-1:0] mode);
    send_word(mode, CHAR_W'($urandom), ROWF_W'($urandom), COLF_W'($urandom), 1'b0, '0);
  endtask

  task automatic send_read_near();
    int unsigned       pick;
    logic [ROWF_W-1:0] r;
    logic [COLF_W-1:0] c;
    pick = $urandom_range(99);
    if (pick < 55) begin
      r = ROWF_W'(cursor_row_q);
      c = COLF_W'($urandom_range(cursor_col_q, cursor_col_q > 3 ? cursor_col_q - 3 : 0));
    end else if (pick < 85) begin
      r = ROWF_W'($urandom_range(TEXT_ROWS - 1));
      c = COLF_W'($urandom_range(COLS - 1));
    end else begin
      r = ROWF_W'($urandom);
      c = COLF_W'($urandom);
      if (r < TEXT_ROWS && c < COLS) r = ROWF_W'($urandom_range(31, TEXT_ROWS));
    end
    send_word(MODE_READ, CHAR_W'($urandom), r, c, 1'b0, '0);
  endtask

  // Holds the input off until every outstanding word has reported.
  task automatic drain_reports();
    in_ch.valid <= 1'b0;
    do @(negedge clk_i); while (expected_reports.size() != 0);
  endtask

  task automatic write_attr(input logic [CHAR_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    text_attr_q = value;
  endtask

  task automatic run_random_phase(input int unsigned n_words);
    int unsigned start_count;
    int unsigned kind;
    bit          paused;
    start_count = words_sent;
    paused = 1'b0;
    // Push the cursor toward the bottom so that line feeds and wraps scroll.
    repeat ($urandom_range(26, 20)) send_put(KEY_LF);
    repeat ($urandom_range(90, 78)) send_put(CHAR_W'($urandom_range(255, 32)));
    while (words_sent - start_count < n_words) begin
      if (!paused && words_sent - start_count >= n_words / 2) begin
        drain_reports();
        paused = 1'b1;
      end
      kind = $urandom_range(99);
      if (kind < 45) begin
        repeat ($urandom_range(30, 1)) send_put(random_char());
      end else if (kind < 50) begin
        repeat ($urandom_range(85, 75)) send_put(CHAR_W'($urandom_range(255, 32)));
      end else if (kind < 60) begin
        repeat ($urandom_range(8, 1)) send_put(KEY_BACKSPACE);
      end else if (kind < 72) begin
        repeat ($urandom_range(6, 1)) send_read_near();
      end else if (kind < 82) begin
        repeat (($urandom_range(3) == 0) ? $urandom_range(26, 8) : $urandom_range(4, 1))
          send_put(KEY_LF);
      end else if (kind < 87) begin
        send_plain(MODE_CLEAR);
      end else if (kind < 94) begin
        repeat ($urandom_range(3, 1)) send_plain(MODE_RESERVED);
      end else begin
        send_put(KEY_CR);
      end
    end
  endtask

  always @(negedge clk_i) begin
    out_ch.ready <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    console_report_t got;
    console_report_t want;
    if (out_ch.valid && out_ch.ready) begin
      got = '{out_ch.cursor_row, out_ch.cursor_col, out_ch.cursor_location,
              out_ch.cell_char, out_ch.cell_attr};
      if (expected_reports.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_MAX)
          $display("unexpected word: row %0d col %0d loc %h char %h attr %h",
                   got.cursor_row, got.cursor_col, got.cursor_location,
                   got.cell_char, got.cell_attr);
      end else begin
        want = expected_reports.pop_front();
        if (got !== want) begin
          error_count++;
          if (error_count <= REPORT_MAX)
            $display({"mismatch: expected row %0d col %0d loc %h char %h attr %h, ",
                      "got row %0d col %0d loc %h char %h attr %h"},
                     want.cursor_row, want.cursor_col, want.cursor_location,
                     want.cell_char, want.cell_attr, got.cursor_row, got.cursor_col,
                     got.cursor_location, got.cell_char, got.cell_attr);
        end
      end
    end
    if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int unsigned send_pcts [3];
    int unsigned recv_pcts [3];
    logic [CHAR_W-1:0] phase_attr [3];
    send_pcts  = '{26, 85, 0};
    recv_pcts  = '{85, 26, 0};
    phase_attr = '{8'h00, 8'hFF, CHAR_W'($urandom_range(254, 1))};

    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    in_ch.valid     = 1'b0;
    in_ch.mode      = MODE_PUT;
    in_ch.char_code = '0;
    in_ch.cell_row  = '0;
    in_ch.cell_col  = '0;
    out_ch.ready    = 1'b0;
    error_count     = 0;
    stall_cycles    = 0;
    words_sent      = 0;
    send_idle_pct   = send_pcts[0];
    recv_idle_pct   = recv_pcts[0];
    text_attr_q     = RESET_ATTR;
    cursor_row_q    = 0;
    cursor_col_q    = 0;
    for (int i = 0; i < CELLS; i++) begin
      screen_char[i] = BLANK_CHAR;
      screen_attr[i] = RESET_ATTR;
    end

    // Reads of the cleared screen, out-of-range reads, ignored mode and plain edits.
    directed_rows.push_back(row_typed(MODE_READ, 8'h00, 5'd0, 7'd0,
                                      5'd0, 7'd0, 16'hFFFF, BLANK_CHAR, RESET_ATTR));
    directed_rows.push_back(row_typed(MODE_READ, 8'h00, 5'd23, 7'd79,
                                      5'd0, 7'd0, 16'hFFFF, BLANK_CHAR, RESET_ATTR));
    directed_rows.push_back(row_typed(MODE_READ, 8'h00, 5'd24, 7'd0,
                                      5'd0, 7'd0, 16'hFFFF, 8'h00, 8'h00));
    directed_rows.push_back(row_typed(MODE_READ, 8'h00, 5'd0, 7'd80,
                                      5'd0, 7'd0, 16'hFFFF, 8'h00, 8'h00));
    directed_rows.push_back(row_typed(MODE_READ, 8'hFF, 5'd31, 7'd127,
                                      5'd0, 7'd0, 16'hFFFF, 8'h00, 8'h00));
    directed_rows.push_back(row_typed(MODE_RESERVED, 8'hFF, 5'd31, 7'd127,
                                      5'd0, 7'd0, 16'hFFFF, 8'h00, 8'h00));
    directed_rows.push_back(row_typed(MODE_PUT, KEY_BACKSPACE, 5'd0, 7'd0,
                                      5'd0, 7'd0, 16'hFFFF, 8'h00, 8'h00));
    directed_rows.push_back(row_typed(MODE_PUT, 8'h41, 5'd0, 7'd0,
                                      5'd0, 7'd1, 16'h0000, 8'h00, 8'h00));
    directed_rows.push_back(row_typed(MODE_PUT, 8'hFF, 5'd0, 7'd0,
                                      5'd0, 7'd2, 16'h0001, 8'h00, 8'h00));
    directed_rows.push_back(row_typed(MODE_PUT, 8'h00, 5'd0, 7'd0,
                                      5'd0, 7'd3, 16'h0002, 8'h00, 8'h00));
    directed_rows.push_back(row_typed(MODE_READ, 8'h00, 5'd0, 7'd0,
                                      5'd0, 7'd3, 16'h0002, 8'h41, RESET_ATTR));
    directed_rows.push_back(row_typed(MODE_READ, 8'h00, 5'd0, 7'd1,
                                      5'd0, 7'd3, 16'h0002, 8'hFF, RESET_ATTR));
    directed_rows.push_back(row_typed(MODE_PUT, KEY_BACKSPACE, 5'd0, 7'd0,
                                      5'd0, 7'd2, 16'h0001, 8'h00, 8'h00));
    directed_rows.push_back(row_typed(MODE_PUT, KEY_BACKSPACE, 5'd0, 7'd0,
                                      5'd0, 7'd1, 16'h0000, 8'h00, 8'h00));
    directed_rows.push_back(row_typed(MODE_READ, 8'h00, 5'd0, 7'd1,
                                      5'd0, 7'd1, 16'h0000, BLANK_CHAR, RESET_ATTR));
    directed_rows.push_back(row_typed(MODE_PUT, KEY_CR, 5'd0, 7'd0,
                                      5'd0, 7'd0, 16'hFFFF, 8'h00, 8'h00));
    directed_rows.push_back(row_typed(MODE_PUT, KEY_LF, 5'd0, 7'd0,
                                      5'd1, 7'd0, 16'h004F, 8'h00, 8'h00));
    directed_rows.push_back(row_typed(MODE_PUT, 8'h5A, 5'd0, 7'd0,
                                      5'd1, 7'd1, 16'h0050, 8'h00, 8'h00));
    directed_rows.push_back(row_typed(MODE_READ, 8'h00, 5'd1, 7'd0,
                                      5'd1, 7'd1, 16'h0050, 8'h5A, RESET_ATTR));
    directed_rows.push_back(row_predicted(MODE_PUT, 8'h7F, 5'd0, 7'd0));
    directed_rows.push_back(row_typed(MODE_CLEAR, 8'h00, 5'd0, 7'd0,
                                      5'd0, 7'd0, 16'hFFFF, 8'h00, 8'h00));
    directed_rows.push_back(row_typed(MODE_READ, 8'h00, 5'd1, 7'd0,
                                      5'd0, 7'd0, 16'hFFFF, BLANK_CHAR, RESET_ATTR));
    directed_rows.push_back(row_predicted(MODE_PUT, 8'h80, 5'd31, 7'd127));

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_rows[i])
      send_word(directed_rows[i].mode, directed_rows[i].ch, directed_rows[i].row,
                directed_rows[i].col, directed_rows[i].typed, directed_rows[i].want);

    for (int p = 0; p < 3; p++) begin
      drain_reports();
      send_idle_pct = send_pcts[p];
      recv_idle_pct = recv_pcts[p];
      write_attr(phase_attr[p]);
      run_random_phase(PHASE_WORDS);
    end

    drain_reports();
    repeat (20) @(negedge clk_i);
    if (error_count == 0 && expected_reports.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/tcw_pkg.sv
design/tcw_in_if.sv
design/tcw_out_if.sv
design/tcw_ram.sv
design/tcw_front.sv
design/tcw_cmd_queue.sv
design/tcw_back.sv
design/text_console_writer.sv
dv/tb_top.sv
